// ===== design/wsm_pkg.sv =====
// Shared types, codes and helpers for the wildcard star matcher.
// No dependencies; imported by wsm_cell and wildcard_star_matcher.
package wsm_pkg;

	// Field widths fixed by the item format
	localparam int unsigned OP_W   = 2;
	localparam int unsigned POS_W  = 6;
	localparam int unsigned CHAR_W = 16;
	localparam int unsigned CFG_W  = 7;

	// Operation codes
	localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
	localparam logic [OP_W-1:0] OP_TEXT  = 2'd1;
	localparam logic [OP_W-1:0] OP_END   = 2'd2;

	localparam logic [CHAR_W-1:0] STAR_CODE = 16'd42;

	// Signals handed from one cell to the next along the row
	typedef struct packed {
		logic clos;  // star closure carry of the current set
		logic shift; // cell matched the text character, advance one place
		logic clos2; // star closure carry of the updated set
	} link_t;

	// ASCII upper-case letters fold to lower case, nothing else changes
	function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] r;
		r = c;
		if (c >= 16'd65 && c <= 16'd90) begin
			r = c + 16'd32;
		end
		return r;
	endfunction

endpackage

// ===== design/wsm_cell.sv =====
// One pattern cell: holds a folded pattern character and its active bit.
// Depends on wsm_pkg for the link struct, codes and case folding.
module wsm_cell #(
	parameter bit IS_FIRST = 1'b0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,         // cell lies below the pattern end
	input  logic                        write_hit,  // pattern write aimed at this cell
	input  logic [wsm_pkg::CHAR_W-1:0]  write_char,
	input  logic [wsm_pkg::CHAR_W-1:0]  text_char,  // already folded
	input  logic                        text_step,
	input  logic                        restart,
	input  wsm_pkg::link_t              link_in,
	output wsm_pkg::link_t              link_out,
	output logic                        closed      // active bit after star closure
);
	import wsm_pkg::*;

	logic [CHAR_W-1:0] pat_q;
	logic              act_q;
	logic              is_star;
	logic              hit;
	logic              nxt;
	logic              nxt_closed;

	// Pattern character, stored folded (folding never yields a star)
	always_ff @(posedge clk) begin
		if (write_hit) begin
			pat_q <= fold_case(write_char);
		end
	end

	assign is_star = (pat_q == STAR_CODE);
	assign hit     = (pat_q == text_char);

	// Closure, step and closure of the new set
	assign closed          = act_q | link_in.clos;
	assign nxt             = (closed & is_star & en) | link_in.shift;
	assign nxt_closed      = nxt | link_in.clos2;
	assign link_out.clos   = closed & is_star & en;
	assign link_out.shift  = closed & ~is_star & hit & en;
	assign link_out.clos2  = nxt_closed & is_star & en;

	// Active bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= IS_FIRST;
		end else if (restart) begin
			act_q <= IS_FIRST;
		end else if (text_step) begin
			act_q <= nxt_closed;
		end
	end

endmodule

// ===== design/wildcard_star_matcher.sv =====
// Top level of the wildcard star matcher: row of pattern cells plus output skid.
// Depends on wsm_pkg and wsm_cell.
//
// Usage: load pattern characters with operation write (position, character),
// set pattern_length through cfg_we/cfg_wdata, then stream text characters
// one beat each and close the text with an end beat. Only an end beat gives
// a result beat on the output channel: matched is 1 when the whole text
// matched the whole pattern; '*' matches any run, ASCII letters fold case.
// A new input beat is taken every cycle while in_stall is low. The
// active set of all cells is updated through a combinational closure and
// shift chain along the row, which sets the clock period for long patterns.
// The result of an end beat appears on out_valid the cycle after it is taken
// when the output register is free; otherwise it waits in the skid stage.
// An output register and a one-entry skid stage decouple the channels: input
// keeps flowing while a result waits, and in_stall rises only when both hold
// a result. Reset clears pattern_length, the match state (position zero
// active) and both output stages; pattern entries are undefined until written.
module wildcard_star_matcher #(
	parameter int unsigned PATTERN_MAX = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [wsm_pkg::OP_W-1:0]    operation,
	input  logic [wsm_pkg::POS_W-1:0]   position,
	input  logic [wsm_pkg::CHAR_W-1:0]  character,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        matched,
	input  logic                        cfg_we,
	input  logic [wsm_pkg::CFG_W-1:0]   cfg_wdata
);
	import wsm_pkg::*;

	localparam int unsigned LEN_W = $clog2(PATTERN_MAX + 1);
	localparam int unsigned CMP_W = (LEN_W > CFG_W) ? LEN_W : CFG_W;
	localparam int unsigned POS_RANGE = 2 ** POS_W;

	logic [CFG_W-1:0]   pattern_length_q;
	logic [CMP_W-1:0]   len_ext;
	logic [LEN_W-1:0]   used_len;
	logic               in_acc;
	logic               wr_acc;
	logic               text_acc;
	logic               end_acc;
	logic [CHAR_W-1:0]  text_fold;
	logic [PATTERN_MAX-1:0] cell_en;
	logic [PATTERN_MAX-1:0] write_hit;
	link_t              link [0:PATTERN_MAX];
	logic [PATTERN_MAX:0]   closed_set;
	logic               last_q;
	logic               last_nxt;
	logic               result;
	logic               out_valid_q;
	logic               out_data_q;
	logic               skid_valid_q;
	logic               skid_data_q;
	logic               out_free;

	// Pattern length register, saturated to the cell count on use
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_length_q <= '0;
		end else if (cfg_we) begin
			pattern_length_q <= cfg_wdata;
		end
	end

	assign len_ext  = CMP_W'(pattern_length_q);
	assign used_len = (len_ext > CMP_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : LEN_W'(len_ext);

	// Input beat decode
	assign in_acc    = in_valid & ~in_stall;
	assign wr_acc    = in_acc & (operation == OP_WRITE);
	assign text_acc  = in_acc & (operation == OP_TEXT);
	assign end_acc   = in_acc & (operation == OP_END);
	assign text_fold = fold_case(character);

	assign link[0] = '0;

	// Row of cells
	for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
		assign cell_en[i] = (LEN_W'(i) < used_len);
		if (i < POS_RANGE) begin : g_hit
			assign write_hit[i] = wr_acc & (position == POS_W'(i));
		end else begin : g_nohit
			assign write_hit[i] = 1'b0;
		end

		wsm_cell #(
			.IS_FIRST(i == 0)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (cell_en[i]),
			.write_hit  (write_hit[i]),
			.write_char (character),
			.text_char  (text_fold),
			.text_step  (text_acc),
			.restart    (end_acc),
			.link_in    (link[i]),
			.link_out   (link[i+1]),
			.closed     (closed_set[i])
		);
	end

	// Pattern end position: active when the whole pattern has been consumed
	assign closed_set[PATTERN_MAX] = last_q | link[PATTERN_MAX].clos;
	assign last_nxt = link[PATTERN_MAX].shift | link[PATTERN_MAX].clos2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= 1'b0;
		end else if (end_acc) begin
			last_q <= 1'b0;
		end else if (text_acc) begin
			last_q <= last_nxt;
		end
	end

	assign result = closed_set[used_len];

	// Output register with skid stage
	assign out_free = ~out_valid_q | ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= end_acc;
			end
		end else if (end_acc) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
			end else if (end_acc) begin
				out_data_q <= result;
			end
		end else if (end_acc) begin
			skid_data_q <= result;
		end
	end

	assign in_stall  = skid_valid_q;
	assign out_valid = out_valid_q;
	assign matched   = out_data_q;

	// Checks
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("skid holds a result while the output stage is empty");

	a_end_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(end_acc && !out_valid) |=> out_valid)
		else $error("end beat into an empty output gave no result");

	a_restart_first: assert property (@(posedge clk) disable iff (!arst_n)
		end_acc |=> closed_set[0])
		else $error("position zero not active after end of text");

	a_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall && skid_valid_q) |=> (out_valid && skid_valid_q))
		else $error("pending result dropped while stalled");

endmodule

// ===== dv/wildcard_star_matcher_tb.sv =====
// Self-checking testbench for wildcard_star_matcher: a directed table, then random patterns
// and texts, each checked against a bit-level active-set predictor of the star matcher.
// Depends on wsm_pkg and the wildcard_star_matcher RTL only.
module wildcard_star_matcher_tb;
	import wsm_pkg::*;

	localparam logic [OP_W-1:0]   OP_UNUSED   = 2'd3;
	localparam int unsigned       DEPTH       = 64;
	localparam logic [CHAR_W-1:0] CH_UP_A     = 16'd65;
	localparam logic [CHAR_W-1:0] CH_UP_Z     = 16'd90;
	localparam logic [CHAR_W-1:0] CH_LO_A     = 16'd97;
	localparam logic [CHAR_W-1:0] CH_LO_Z     = 16'd122;
	localparam logic [CHAR_W-1:0] CASE_GAP    = 16'd32;
	localparam int unsigned       RND_ITEMS   = 700;
	localparam int unsigned       HOLD_CYCLES = 300;
	localparam int unsigned       SETTLE      = 4;
	localparam int unsigned       DRAIN       = 20;

	// Directed table row: a beat, or a length write when is_cfg is set (value in ch)
	typedef struct packed {
		logic              is_cfg;
		logic [OP_W-1:0]   op;
		logic [POS_W-1:0]  pos;
		logic [CHAR_W-1:0] ch;
		logic              chk;  // want holds the result read off by hand
		logic              want;
	} dir_row_t;

	localparam int unsigned DIR_N = 28;
	localparam dir_row_t DIR_TBL [DIR_N] = '{
		'{1'b0, OP_END,    6'd0,  16'd0,         1'b1, 1'b1}, // empty text, empty pattern
		'{1'b0, OP_TEXT,   6'd63, CH_LO_A,       1'b0, 1'b0},
		'{1'b0, OP_END,    6'd0,  16'd0,         1'b1, 1'b0}, // text against empty pattern
		'{1'b0, OP_UNUSED, 6'd63, 16'hFFFF,      1'b0, 1'b0}, // unused code, ignored
		'{1'b0, OP_END,    6'd63, 16'hFFFF,      1'b1, 1'b1},
		'{1'b0, OP_WRITE,  6'd0,  STAR_CODE,     1'b0, 1'b0},
		'{1'b0, OP_WRITE,  6'd1,  CH_UP_A,       1'b0, 1'b0},
		'{1'b0, OP_WRITE,  6'd2,  16'hFFFF,      1'b0, 1'b0},
		'{1'b0, OP_WRITE,  6'd63, 16'h0000,      1'b0, 1'b0}, // top entry
		'{1'b1, OP_WRITE,  6'd0,  16'd1,         1'b0, 1'b0}, // pattern: lone star
		'{1'b0, OP_END,    6'd0,  16'd0,         1'b1, 1'b1}, // star takes an empty run
		'{1'b0, OP_TEXT,   6'd0,  16'h0000,      1'b0, 1'b0}, // zero code is a plain char
		'{1'b0, OP_TEXT,   6'd0,  16'hFFFF,      1'b0, 1'b0},
		'{1'b0, OP_END,    6'd0,  16'd0,         1'b1, 1'b1},
		'{1'b1, OP_WRITE,  6'd0,  16'd3,         1'b0, 1'b0}, // pattern: * A FFFF
		'{1'b0, OP_TEXT,   6'd0,  CH_LO_Z,       1'b0, 1'b0},
		'{1'b0, OP_TEXT,   6'd0,  CH_LO_A,       1'b0, 1'b0}, // matches A after case folding
		'{1'b0, OP_TEXT,   6'd0,  16'hFFFF,      1'b0, 1'b0},
		'{1'b0, OP_END,    6'd0,  16'd0,         1'b1, 1'b1},
		'{1'b0, OP_TEXT,   6'd0,  CH_UP_A - 16'd1, 1'b0, 1'b0}, // '@' is not folded
		'{1'b0, OP_END,    6'd0,  16'd0,         1'b1, 1'b0},
		'{1'b0, OP_WRITE,  6'd3,  16'h0000,      1'b0, 1'b0},
		'{1'b1, OP_WRITE,  6'd0,  16'd4,         1'b0, 1'b0},
		'{1'b0, OP_TEXT,   6'd0,  CH_UP_A,       1'b0, 1'b0},
		'{1'b0, OP_WRITE,  6'd2,  CH_LO_A,       1'b0, 1'b0}, // rewrite in mid text
		'{1'b0, OP_TEXT,   6'd0,  CH_LO_A,       1'b0, 1'b0},
		'{1'b0, OP_TEXT,   6'd0,  16'h0000,      1'b0, 1'b0},
		'{1'b0, OP_END,    6'd0,  16'd0,         1'b0, 1'b0}
	};

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [OP_W-1:0]   operation;
	logic [POS_W-1:0]  position;
	logic [CHAR_W-1:0] character;
	logic              out_valid;
	logic              out_stall;
	logic              matched;
	logic              cfg_we;
	logic [CFG_W-1:0]  cfg_wdata;

	// Predictor state
	logic [CHAR_W-1:0] pat_mem [DEPTH];
	logic [DEPTH:0]    live_set;
	logic [CFG_W-1:0]  pat_len;
	logic              expected_matches [$];

	bit          tx_idle_on;
	bit          rx_idle_on;
	bit          hold_off_req;
	bit          hold_done;
	int unsigned err_count = 0;
	int unsigned beats_taken;
	logic        mon_want;

	wildcard_star_matcher #(
		.PATTERN_MAX(DEPTH)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.operation(operation),
		.position (position),
		.character(character),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.matched  (matched),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Run limit
	initial begin
		#400000;
		$display("FAILURE");
		$finish;
	end

	// Predictor helpers
	function automatic int unsigned used_span();
		return (pat_len > DEPTH) ? DEPTH : int'(pat_len);
	endfunction

	function automatic logic [CHAR_W-1:0] to_lower(input logic [CHAR_W-1:0] c);
		if (c >= CH_UP_A && c <= CH_UP_Z) begin
			return c + CASE_GAP;
		end
		return c;
	endfunction

	// Stars can be skipped without taking text, so carry each live star forward
	function automatic logic [DEPTH:0] skip_stars(input logic [DEPTH:0] s, input int unsigned n);
		for (int i = 0; i < n; i++) begin
			if (s[i] && pat_mem[i] == STAR_CODE) begin
				s[i+1] = 1'b1;
			end
		end
		return s;
	endfunction

	task automatic advance_matcher(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
			input logic [CHAR_W-1:0] ch);
		logic [DEPTH:0] cur;
		logic [DEPTH:0] nxt;
		int unsigned    n;
		n = used_span();
		case (op)
			OP_WRITE: begin
				pat_mem[pos] = ch;
			end
			OP_TEXT: begin
				cur = skip_stars(live_set, n);
				nxt = '0;
				for (int i = 0; i < n; i++) begin
					if (cur[i]) begin
						if (pat_mem[i] == STAR_CODE) begin
							nxt[i] = 1'b1;
						end else if (to_lower(pat_mem[i]) == to_lower(ch)) begin
							nxt[i+1] = 1'b1;
						end
					end
				end
				live_set = skip_stars(nxt, n);
			end
			OP_END: begin
				cur = skip_stars(live_set, n);
				expected_matches = {expected_matches, cur[n]};
				live_set = '0;
				live_set[0] = 1'b1;
			end
			default: begin
			end
		endcase
	endtask

	task automatic report_mismatch(input string what, input logic got, input logic want);
		$display("%0t: mismatch on %s, got %b, want %b", $time, what, got, want);
		err_count++;
	endtask

	// Character pickers: a small alphabet keeps matches common
	function automatic logic [CHAR_W-1:0] flip_case(input logic [CHAR_W-1:0] c);
		if (((c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z))
				&& $urandom_range(0, 1)) begin
			return c ^ CASE_GAP;
		end
		return c;
	endfunction

	function automatic logic [CHAR_W-1:0] edge_char();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return '1;
			2:       return CH_UP_A - 16'd1;
			3:       return CH_UP_Z + 16'd1;
			4:       return CH_LO_A - 16'd1;
			default: return CH_LO_Z + 16'd1;
		endcase
	endfunction

	function automatic logic [CHAR_W-1:0] pat_char();
		case ($urandom_range(0, 9))
			0, 1, 2: return STAR_CODE;
			3:       return edge_char();
			4:       return CHAR_W'($urandom);
			default: return flip_case(CH_LO_A + CHAR_W'($urandom_range(0, 3)));
		endcase
	endfunction

	function automatic logic [CHAR_W-1:0] text_char();
		case ($urandom_range(0, 9))
			0:       return STAR_CODE;
			1:       return edge_char();
			2:       return CHAR_W'($urandom);
			default: return flip_case(CH_LO_A + CHAR_W'($urandom_range(0, 3)));
		endcase
	endfunction

	// Offer one beat, with an occasional idle burst first, and wait for it to be taken
	task automatic send_beat(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
			input logic [CHAR_W-1:0] ch);
		if (tx_idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		position  <= pos;
		character <= ch;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		advance_matcher(op, pos, ch);
		if (op != OP_UNUSED) begin
			beats_taken++;
		end
	endtask

	// Length writes only once the block has gone quiet
	task automatic set_length(input logic [CFG_W-1:0] v);
		in_valid <= 1'b0;
		while (expected_matches.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we  <= 1'b0;
		pat_len = v;
	endtask

	// One text: either built from the pattern (sometimes broken) or plain noise
	task automatic run_text(input bit well_formed);
		logic [CHAR_W-1:0] txt [$];
		int unsigned       n;
		int unsigned       k;
		int unsigned       at;
		txt = {};
		if (well_formed) begin
			n = used_span();
			for (int i = 0; i < n; i++) begin
				if (pat_mem[i] == STAR_CODE) begin
					k = $urandom_range(0, 3);
					repeat (k) txt = {txt, text_char()};
				end else begin
					txt = {txt, flip_case(pat_mem[i])};
				end
			end
			if ($urandom_range(0, 3) == 0) begin
				if (txt.size() != 0 && $urandom_range(0, 1)) begin
					at = $urandom_range(0, txt.size() - 1);
					txt.delete(at);
				end else begin
					txt = {txt, text_char()};
				end
			end
		end else begin
			k = $urandom_range(0, 6);
			repeat (k) txt = {txt, text_char()};
		end
		foreach (txt[i]) begin
			if ($urandom_range(0, 19) == 0) begin
				send_beat(OP_WRITE, POS_W'($urandom), pat_char());
			end
			if ($urandom_range(0, 29) == 0) begin
				send_beat(OP_UNUSED, POS_W'($urandom), CHAR_W'($urandom));
			end
			send_beat(OP_TEXT, POS_W'($urandom), txt[i]);
		end
		send_beat(OP_END, POS_W'($urandom), CHAR_W'($urandom));
	endtask

	// Result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_matches.size() == 0) begin
				report_mismatch("unexpected result beat", matched, 1'bx);
			end else begin
				mon_want = expected_matches.pop_front();
				if (matched !== mon_want) begin
					report_mismatch("matched", matched, mon_want);
				end
			end
		end
	end

	// Receiver: random stall bursts, plus one long hold-off to back the block up
	initial begin
		out_stall = 1'b0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_req && !hold_done) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
				hold_done = 1'b1;
			end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Stimulus
	initial begin
		dir_row_t          row;
		int unsigned       phase;
		int unsigned       rnd_start;
		int unsigned       n_texts;
		logic [CFG_W-1:0]  len;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		operation    = OP_WRITE;
		position     = '0;
		character    = '0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		tx_idle_on   = 1'b1;
		rx_idle_on   = 1'b1;
		hold_off_req = 1'b0;
		beats_taken  = 0;
		pat_len      = '0;
		live_set     = '0;
		live_set[0]  = 1'b1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		for (int r = 0; r < DIR_N; r++) begin
			row = DIR_TBL[r];
			if (row.is_cfg) begin
				set_length(row.ch[CFG_W-1:0]);
			end else begin
				send_beat(row.op, row.pos, row.ch);
				if (row.chk) begin
					expected_matches[$] = row.want;
				end
			end
		end

		// Fill the whole store so any length reads written entries only
		for (int i = 0; i < DEPTH; i++) begin
			send_beat(OP_WRITE, POS_W'(i), pat_char());
		end

		// Random phases: new length and pattern, then a run of texts
		rnd_start = beats_taken;
		phase = 0;
		while (beats_taken - rnd_start < RND_ITEMS) begin
			case (phase)
				0: len = '1;
				1: len = '0;
				2: len = CFG_W'(DEPTH);
				3: len = CFG_W'(DEPTH + 1);
				default: begin
					case ($urandom_range(0, 9))
						0:       len = CFG_W'($urandom_range(0, 127));
						1:       len = CFG_W'(DEPTH);
						default: len = CFG_W'($urandom_range(1, 8));
					endcase
				end
			endcase
			set_length(len);
			for (int i = 0; i < ((len > DEPTH) ? DEPTH : int'(len)); i++) begin
				send_beat(OP_WRITE, POS_W'(i), pat_char());
			end
			if (phase == 1) begin
				hold_off_req = 1'b1;
				repeat (10) send_beat(OP_END, POS_W'($urandom), CHAR_W'($urandom));
			end
			// Long patterns give long texts, so fewer of them
			n_texts = (len > 16) ? 2 : $urandom_range(4, 8);
			for (int t = 0; t < n_texts; t++) begin
				run_text($urandom_range(0, 9) < 7);
				if (beats_taken - rnd_start > RND_ITEMS * 7 / 8) begin
					tx_idle_on = 1'b0;
					rx_idle_on = 1'b0;
				end
			end
			phase++;
		end

		// Drain and finish
		in_valid <= 1'b0;
		while (expected_matches.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (err_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
